[design/brpf_pkg.sv]
`timescale 1ns / 1ps

package brpf_pkg;

   localparam int PALETTE_ENTRIES_DEFAULT = 256;
   localparam int QUEUE_DEPTH = 4;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_FORMAT_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT_BITS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BITS_PER_PIXEL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_OFFSET = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_PIXELS = 3'd4;

   localparam logic [2:0] MODE_COPY = 3'd0;
   localparam logic [2:0] MODE_REALIGN = 3'd1;
   localparam logic [2:0] MODE_PACK12 = 3'd2;
   localparam logic [2:0] MODE_ALPHA = 3'd3;
   localparam logic [2:0] MODE_PALETTE = 3'd4;

   localparam logic FUNC_PAL_WRITE = 1'b0;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_BYTES = 2'd1;
   localparam logic [1:0] KIND_PALETTE = 2'd2;

   localparam logic [7:0] ALPHA_LIMIT = 8'd127;

   // work descriptor handed from front to back
   typedef struct packed {
      logic [1:0]      kind;
      logic [2:0][7:0] bytes;  // ready bytes, or palette color for a write
      logic [1:0]      count;  // number of ready bytes
      logic            last;   // end of row flag on the final byte
      logic [7:0]      pix;    // source byte of indices, or write index
      logic [1:0]      lb;     // log2 of index width
      logic [2:0]      first;  // first pixel position in the byte
      logic [3:0]      npix;   // pixels to expand
   } desc_type;

endpackage

[design/brpf_ifs.sv]
`timescale 1ns / 1ps

interface brpf_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [7:0]  palette_index;
   logic [23:0] palette_color;
   logic [31:0] row_data;
   logic        last_of_row;

   modport source (output valid, func, palette_index, palette_color, row_data, last_of_row,
                   input ready);
   modport sink (input valid, func, palette_index, palette_color, row_data, last_of_row,
                 output ready);
endinterface

interface brpf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_item;
   logic       end_of_row;

   modport source (output valid, out_byte, last_of_item, end_of_row, input ready);
   modport sink (input valid, out_byte, last_of_item, end_of_row, output ready);
endinterface

[design/bitmap_row_pixel_formatter_top.sv]
`timescale 1ns / 1ps

// channel   dir  transfer when        payload
// req_ch    in   valid && ready       func, palette_index, palette_color, row_data, last_of_row
// rsp_ch    out  valid && ready       out_byte, last_of_item, end_of_row
// csr_*     in   csr_write_en high    csr_index, csr_wdata
//
// one output byte per cycle while rsp_ch does not stall; copy items give a single byte
// palette items begin with a palette read, then give three bytes per pixel
// palette writes are done in the back end and give no transfer on rsp_ch
// reset is synchronous and clears the queue, row state and config; the palette is not cleared
// a four-entry queue between front and back keeps req_ch open while rsp_ch stalls, until the queue is full

module bitmap_row_pixel_formatter_top import brpf_pkg::*; #(
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   brpf_req_if.sink              req_ch,
   brpf_rsp_if.source            rsp_ch,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic     q_push, q_full, q_pop, q_empty, back_busy;
   desc_type q_data, q_head;

   brpf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_data       (q_data)
   );

   brpf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   brpf_back #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (q_head),
      .empty  (q_empty),
      .pop    (q_pop),
      .busy   (back_busy),
      .rsp_ch (rsp_ch)
   );

`ifndef NO_ASSERTIONS
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue popped while empty");

   a_eor_on_item_end: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.end_of_row |-> rsp_ch.last_of_item)
      else $error("end of row not on the final byte of an item");

   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid && q_empty && !back_busy)
      else $error("state not cleared by reset");
`endif

endmodule

[design/brpf_front.sv]
`timescale 1ns / 1ps

module brpf_front import brpf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   brpf_req_if.sink              req_ch,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  q_full,
   output logic                  q_push,
   output desc_type              q_data
);

   logic [2:0]  format_mode_ff;
   logic        invert_bits_ff;
   logic [3:0]  bits_per_pixel_ff;
   logic [2:0]  origin_offset_ff;
   logic [15:0] row_pixels_ff;

   logic [7:0]  held_byte_ff, held_byte_in;
   logic [11:0] held_sample_ff, held_sample_in;
   logic        sample_pending_ff, sample_pending_in;
   logic        row_started_ff, row_started_in;
   logic [15:0] pixels_left_ff, pixels_left_in;

   logic        accept;
   logic        push;
   desc_type    d;
   logic [7:0]  byte_v, inv8, realign, tail;
   logic [15:0] smp;
   logic [23:0] rgb;
   logic [1:0]  lb;
   logic [3:0]  ppb, avail, npix;
   logic [2:0]  first;
   logic [15:0] pl, pl_next;

   assign req_ch.ready = !q_full;
   assign accept = req_ch.valid && !q_full;
   assign q_push = accept && push;
   assign q_data = d;

   always_comb begin
      byte_v = req_ch.row_data[7:0];
      inv8 = {8{invert_bits_ff}};
      realign = 8'({8'b0, held_byte_ff} << origin_offset_ff)
              | 8'(byte_v >> (4'd8 - {1'b0, origin_offset_ff}));
      tail = 8'({8'b0, byte_v} << origin_offset_ff) ^ inv8;
      smp = req_ch.row_data[15:0] ^ {16{invert_bits_ff}};
      rgb = (byte_v < ALPHA_LIMIT) ? 24'hffffff : req_ch.row_data[31:8];

      case (bits_per_pixel_ff)
         4'd1: lb = 2'd0;
         4'd2: lb = 2'd1;
         4'd4: lb = 2'd2;
         default: lb = 2'd3;
      endcase
      pl = row_started_ff ? pixels_left_ff : row_pixels_ff;
      first = row_started_ff ? 3'd0 : (origin_offset_ff >> lb);
      ppb = 4'd8 >> lb;
      avail = ppb - {1'b0, first};
      npix = (pl < {12'b0, avail}) ? pl[3:0] : avail;
      pl_next = pl - {12'b0, npix};

      d = '0;
      d.kind = KIND_BYTES;
      d.last = req_ch.last_of_row;
      push = 1'b0;
      held_byte_in = held_byte_ff;
      held_sample_in = held_sample_ff;
      sample_pending_in = sample_pending_ff;
      row_started_in = row_started_ff;
      pixels_left_in = pixels_left_ff;

      if (req_ch.func == FUNC_PAL_WRITE) begin
         d.kind = KIND_WRITE;
         d.pix = req_ch.palette_index;
         d.bytes = req_ch.palette_color;
         push = 1'b1;
      end else begin
         case (format_mode_ff)
            MODE_COPY: begin
               d.bytes[0] = byte_v ^ inv8;
               d.count = 2'd1;
               push = 1'b1;
            end
            MODE_REALIGN: begin
               if (row_started_ff) begin
                  d.bytes[0] = realign ^ inv8;
                  d.bytes[1] = tail;
                  d.count = req_ch.last_of_row ? 2'd2 : 2'd1;
                  push = 1'b1;
               end else if (req_ch.last_of_row) begin
                  d.bytes[0] = tail;
                  d.count = 2'd1;
                  push = 1'b1;
               end
               held_byte_in = byte_v;
               row_started_in = !req_ch.last_of_row;
            end
            MODE_PACK12: begin
               if (sample_pending_ff) begin
                  d.bytes[0] = held_sample_ff[11:4];
                  d.bytes[1] = {held_sample_ff[3:0], smp[15:12]};
                  d.bytes[2] = smp[11:4];
                  d.count = 2'd3;
                  push = 1'b1;
                  sample_pending_in = 1'b0;
               end else if (req_ch.last_of_row) begin
                  d.bytes[0] = smp[15:8];
                  d.bytes[1] = {smp[7:4], 4'b0};
                  d.count = 2'd2;
                  push = 1'b1;
               end else begin
                  held_sample_in = smp[15:4];
                  sample_pending_in = 1'b1;
               end
            end
            MODE_ALPHA: begin
               d.bytes[0] = rgb[23:16];
               d.bytes[1] = rgb[15:8];
               d.bytes[2] = rgb[7:0];
               d.count = 2'd3;
               push = 1'b1;
            end
            MODE_PALETTE: begin
               d.kind = KIND_PALETTE;
               d.pix = byte_v;
               d.lb = lb;
               d.first = first;
               d.npix = npix;
               d.last = req_ch.last_of_row || (pl_next == 16'd0);
               push = (npix != 4'd0);
               pixels_left_in = pl_next;
               row_started_in = !req_ch.last_of_row;
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_mode_ff <= MODE_COPY;
         invert_bits_ff <= 1'b0;
         bits_per_pixel_ff <= 4'd8;
         origin_offset_ff <= 3'd0;
         row_pixels_ff <= 16'd1;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_FORMAT_MODE: format_mode_ff <= csr_wdata[2:0];
            CSR_INVERT_BITS: invert_bits_ff <= csr_wdata[0];
            CSR_BITS_PER_PIXEL: bits_per_pixel_ff <= csr_wdata[3:0];
            CSR_ORIGIN_OFFSET: origin_offset_ff <= csr_wdata[2:0];
            CSR_ROW_PIXELS: row_pixels_ff <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_byte_ff <= '0;
         held_sample_ff <= '0;
         sample_pending_ff <= 1'b0;
         row_started_ff <= 1'b0;
         pixels_left_ff <= '0;
      end else if (accept) begin
         held_byte_ff <= held_byte_in;
         held_sample_ff <= held_sample_in;
         sample_pending_ff <= sample_pending_in;
         row_started_ff <= row_started_in;
         pixels_left_ff <= pixels_left_in;
      end
   end

endmodule

[design/brpf_queue.sv]
`timescale 1ns / 1ps

module brpf_queue import brpf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_data,
   output logic     full,
   input  logic     pop,
   output desc_type head,
   output logic     empty
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   desc_type        entries_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]     count_ff;

   assign full = (count_ff == (PW+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

[design/brpf_back.sv]
`timescale 1ns / 1ps

module brpf_back import brpf_pkg::*; #(
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  desc_type head,
   input  logic     empty,
   output logic     pop,
   output logic     busy,
   brpf_rsp_if.source rsp_ch
);

   localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

   logic [23:0]     pal_mem_ff [PALETTE_ENTRIES];
   logic [23:0]     rd_color_ff;
   logic            rd_hit_ff;

   logic            busy_ff, busy_in;
   desc_type        desc_ff, desc_in;
   logic [1:0]      ph_ff, ph_in;
   logic [2:0]      pos_ff, pos_in;
   logic [3:0]      rem_ff, rem_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_byte_ff;
   logic            rsp_lio_ff, rsp_eor_ff;

   logic            out_free;
   logic            emit, emit_lio, emit_eor;
   logic [7:0]      emit_byte;
   logic            rd_en, wr_en;
   logic [7:0]      rd_idx;
   logic [23:0]     col;
   logic            final_pix, last_byte;

   function automatic logic [7:0] pix_index(input logic [7:0] src, input logic [1:0] lb,
                                            input logic [2:0] pos);
      logic [7:0] sh;
      sh = src << ({1'b0, pos} << lb);
      case (lb)
         2'd0: return {7'b0, sh[7]};
         2'd1: return {6'b0, sh[7:6]};
         2'd2: return {4'b0, sh[7:4]};
         default: return sh;
      endcase
   endfunction

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign col = rd_hit_ff ? rd_color_ff : 24'd0;
   assign busy = busy_ff;

   always_comb begin
      pop = 1'b0;
      emit = 1'b0;
      emit_byte = '0;
      emit_lio = 1'b0;
      emit_eor = 1'b0;
      rd_en = 1'b0;
      wr_en = 1'b0;
      rd_idx = '0;
      busy_in = busy_ff;
      desc_in = desc_ff;
      ph_in = ph_ff;
      pos_in = pos_ff;
      rem_in = rem_ff;
      final_pix = (rem_ff == 4'd1);
      last_byte = 1'b0;

      if (!busy_ff) begin
         if (!empty) begin
            case (head.kind)
               KIND_WRITE: begin
                  pop = 1'b1;
                  wr_en = 1'b1;
               end
               KIND_BYTES: begin
                  if (out_free) begin
                     last_byte = (head.count == 2'd1);
                     emit = 1'b1;
                     emit_byte = head.bytes[0];
                     emit_lio = last_byte;
                     emit_eor = last_byte && head.last;
                     pop = 1'b1;
                     if (!last_byte) begin
                        busy_in = 1'b1;
                        desc_in = head;
                        ph_in = 2'd1;
                     end
                  end
               end
               KIND_PALETTE: begin
                  pop = 1'b1;
                  busy_in = 1'b1;
                  desc_in = head;
                  ph_in = 2'd0;
                  pos_in = head.first;
                  rem_in = head.npix;
                  rd_en = 1'b1;
                  rd_idx = pix_index(head.pix, head.lb, head.first);
               end
               default: begin
                  pop = 1'b1;
               end
            endcase
         end
      end else if (out_free) begin
         case (desc_ff.kind)
            KIND_BYTES: begin
               last_byte = (ph_ff == desc_ff.count - 2'd1);
               emit = 1'b1;
               emit_byte = desc_ff.bytes[ph_ff];
               emit_lio = last_byte;
               emit_eor = last_byte && desc_ff.last;
               ph_in = ph_ff + 2'd1;
               if (last_byte) begin
                  busy_in = 1'b0;
               end
            end
            KIND_PALETTE: begin
               last_byte = final_pix && (ph_ff == 2'd2);
               emit = 1'b1;
               case (ph_ff)
                  2'd0: emit_byte = col[23:16];
                  2'd1: emit_byte = col[15:8];
                  default: emit_byte = col[7:0];
               endcase
               emit_lio = last_byte;
               emit_eor = last_byte && desc_ff.last;
               if (ph_ff == 2'd2) begin
                  ph_in = 2'd0;
                  if (final_pix) begin
                     busy_in = 1'b0;
                  end else begin
                     pos_in = pos_ff + 3'd1;
                     rem_in = rem_ff - 4'd1;
                     rd_en = 1'b1;
                     rd_idx = pix_index(desc_ff.pix, desc_ff.lb, pos_ff + 3'd1);
                  end
               end else begin
                  ph_in = ph_ff + 2'd1;
               end
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // palette store, one port each way, registered read
   always_ff @(posedge clock) begin
      if (wr_en && ({1'b0, head.pix} < 9'(PALETTE_ENTRIES))) begin
         pal_mem_ff[head.pix[PAL_AW-1:0]] <= head.bytes;
      end
      if (rd_en) begin
         rd_color_ff <= pal_mem_ff[rd_idx[PAL_AW-1:0]];
         rd_hit_ff <= ({1'b0, rd_idx} < 9'(PALETTE_ENTRIES));
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
      ph_ff <= ph_in;
      pos_ff <= pos_in;
      rem_ff <= rem_in;
      if (emit) begin
         rsp_byte_ff <= emit_byte;
         rsp_lio_ff <= emit_lio;
         rsp_eor_ff <= emit_eor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.out_byte = rsp_byte_ff;
   assign rsp_ch.last_of_item = rsp_lio_ff;
   assign rsp_ch.end_of_row = rsp_eor_ff;

endmodule
